>>> rtl/expression_tokenizer_macros.svh
// Assertion helpers used by the tokenizer RTL.
`ifndef EXPRESSION_TOKENIZER_MACROS_SVH
`define EXPRESSION_TOKENIZER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define EXPTOK_ASSERT_IMP(lbl, clk, rst_n, ant, con, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define EXPTOK_ASSERT_NXT(lbl, clk, rst_n, ant, con, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
        else $error(msg);

`endif

>>> rtl/exptok_pkg.sv
package exptok_pkg;

    localparam int MANTISSA_BITS_DEF = 60;
    localparam int POSITION_BITS_DEF = 16;
    localparam int KIND_W            = 5;
    localparam int FRAC_W            = 6;
    localparam int FUNC_COUNT        = 11;
    localparam int RESULT_DEPTH      = 4;

    localparam logic [FRAC_W-1:0] FRAC_MAX = 6'd63;

    typedef enum logic [KIND_W-1:0] {
        KIND_END    = 5'd0,
        KIND_PLUS   = 5'd1,
        KIND_UPLUS  = 5'd2,
        KIND_MINUS  = 5'd3,
        KIND_UMINUS = 5'd4,
        KIND_STAR   = 5'd5,
        KIND_DIV    = 5'd6,
        KIND_POW    = 5'd7,
        KIND_X      = 5'd8,
        KIND_LPAREN = 5'd9,
        KIND_RPAREN = 5'd10,
        KIND_NUMBER = 5'd11,
        KIND_FUNC0  = 5'd12,
        KIND_ERROR  = 5'd23
    } t_kind;

    // Characters the lexer reacts to
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_POINT  = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UPPERX = 8'h58;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_LOWA   = 8'h61;
    localparam logic [7:0] CH_LOWX   = 8'h78;
    localparam logic [7:0] CH_LOWZ   = 8'h7A;

    // Function names, first letter in the low byte, unused bytes zero
    localparam logic [31:0] FUNC_TEXT [FUNC_COUNT] = '{
        32'h006E6973,  // sin
        32'h00736F63,  // cos
        32'h006E6174,  // tan
        32'h686E6973,  // sinh
        32'h68736F63,  // cosh
        32'h686E6174,  // tanh
        32'h00006E6C,  // ln
        32'h00707865,  // exp
        32'h74727173,  // sqrt
        32'h00676F6C,  // log
        32'h00736261   // abs
    };

    localparam logic [2:0] FUNC_LEN [FUNC_COUNT] = '{
        3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd2, 3'd3, 3'd4, 3'd3, 3'd3
    };

endpackage

>>> rtl/exptok_word_match.sv
module exptok_word_match (
    input  logic [31:0]                   i_letters,
    input  logic [2:0]                    i_length,
    input  logic                          i_overlong,
    output logic [exptok_pkg::KIND_W-1:0] o_kind
);

    logic found;

    // Names are distinct, so at most one entry hits
    always_comb begin
        found  = 1'b0;
        o_kind = exptok_pkg::KIND_ERROR;
        for (int i = 0; i < exptok_pkg::FUNC_COUNT; i++) begin
            if (!found && !i_overlong && i_length == exptok_pkg::FUNC_LEN[i]
                    && i_letters == exptok_pkg::FUNC_TEXT[i]) begin
                found  = 1'b1;
                o_kind = exptok_pkg::KIND_FUNC0 + exptok_pkg::KIND_W'(i);
            end
        end
    end

endmodule

>>> rtl/exptok_core.sv
module exptok_core #(
    parameter int MANTISSA_BITS = exptok_pkg::MANTISSA_BITS_DEF,
    parameter int POSITION_BITS = exptok_pkg::POSITION_BITS_DEF,
    parameter int DATA_W        = exptok_pkg::KIND_W + MANTISSA_BITS
                                  + exptok_pkg::FRAC_W + POSITION_BITS + 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [7:0]        i_char,
    output logic [1:0]        o_push_n,
    output logic [DATA_W-1:0] o_data0,
    output logic [DATA_W-1:0] o_data1
);

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_NUM  = 2'd1,
        MODE_WORD = 2'd2
    } t_mode;

    localparam int FW = exptok_pkg::FRAC_W;
    localparam int KW = exptok_pkg::KIND_W;
    localparam logic [MANTISSA_BITS-1:0] MANT_MAX = '1;

    // control state
    t_mode                    r_mode;
    logic [7:0]               r_prev;
    logic [POSITION_BITS-1:0] r_pos;

    // pending number and word
    logic                     r_point,  n_point;
    logic [MANTISSA_BITS-1:0] r_mant,   n_mant;
    logic [FW-1:0]            r_frac,   n_frac;
    logic                     r_sat,    n_sat;
    logic [31:0]              r_letters, n_letters;
    logic [2:0]               r_wlen,   n_wlen;
    logic                     r_long,   n_long;
    t_mode                    n_mode;

    logic is_digit, is_point, is_lower, is_blank;
    logic num_cont, word_cont, second_point, handled, pending;
    logic start_num, start_word, start_num_all, start_word_all;
    logic own_valid, emit_own, prev_unary_p, prev_unary_m;
    logic [KW-1:0]            own_kind, word_kind, flush_kind;
    logic [POSITION_BITS-1:0] own_pos, flush_pos;
    logic                     base_point, base_sat;
    logic [MANTISSA_BITS-1:0] base_mant;
    logic [FW-1:0]            base_frac;
    logic [MANTISSA_BITS+3:0] mant_x10;

    assign is_digit = i_char >= exptok_pkg::CH_ZERO && i_char <= exptok_pkg::CH_NINE;
    assign is_point = i_char == exptok_pkg::CH_POINT;
    assign is_lower = i_char >= exptok_pkg::CH_LOWA && i_char <= exptok_pkg::CH_LOWZ;
    assign is_blank = i_char == exptok_pkg::CH_SPACE || i_char == exptok_pkg::CH_TAB;

    assign num_cont     = r_mode == MODE_NUM && (is_digit || is_point);
    assign word_cont    = r_mode == MODE_WORD && is_lower;
    assign second_point = num_cont && is_point && r_point;
    assign handled      = num_cont || word_cont;
    assign pending      = (!handled || second_point)
                          && (r_mode == MODE_NUM || r_mode == MODE_WORD);

    assign prev_unary_p = r_prev == exptok_pkg::CH_LPAREN || r_prev == exptok_pkg::CH_MINUS
                          || r_prev == exptok_pkg::CH_STAR || r_prev == exptok_pkg::CH_SLASH;
    assign prev_unary_m = r_prev == exptok_pkg::CH_LPAREN || r_prev == exptok_pkg::CH_PLUS
                          || r_prev == exptok_pkg::CH_STAR || r_prev == exptok_pkg::CH_SLASH;

    // token from the character itself, when it is not absorbed
    always_comb begin
        own_valid  = 1'b1;
        own_kind   = exptok_pkg::KIND_END;
        own_pos    = '0;
        start_num  = 1'b0;
        start_word = 1'b0;
        priority if (i_char == exptok_pkg::CH_NUL) begin
            own_kind = exptok_pkg::KIND_END;
        end else if (is_blank) begin
            own_valid = 1'b0;
        end else if (i_char == exptok_pkg::CH_PLUS) begin
            own_kind = prev_unary_p ? exptok_pkg::KIND_UPLUS : exptok_pkg::KIND_PLUS;
        end else if (i_char == exptok_pkg::CH_MINUS) begin
            own_kind = prev_unary_m ? exptok_pkg::KIND_UMINUS : exptok_pkg::KIND_MINUS;
        end else if (i_char == exptok_pkg::CH_STAR) begin
            own_kind = exptok_pkg::KIND_STAR;
        end else if (i_char == exptok_pkg::CH_SLASH) begin
            own_kind = exptok_pkg::KIND_DIV;
        end else if (i_char == exptok_pkg::CH_CARET) begin
            own_kind = exptok_pkg::KIND_POW;
        end else if (i_char == exptok_pkg::CH_LOWX || i_char == exptok_pkg::CH_UPPERX) begin
            own_kind = exptok_pkg::KIND_X;
        end else if (i_char == exptok_pkg::CH_LPAREN) begin
            own_kind = exptok_pkg::KIND_LPAREN;
        end else if (i_char == exptok_pkg::CH_RPAREN) begin
            own_kind = exptok_pkg::KIND_RPAREN;
        end else if (is_digit || is_point) begin
            own_valid = 1'b0;
            start_num = 1'b1;
        end else if (is_lower) begin
            own_valid  = 1'b0;
            start_word = 1'b1;
        end else begin
            own_kind = exptok_pkg::KIND_ERROR;
            own_pos  = r_pos;
        end
    end

    assign emit_own       = !handled && own_valid;
    assign start_num_all  = (!handled && start_num) || second_point;
    assign start_word_all = !handled && start_word;

    exptok_word_match u_match (
        .i_letters  (r_letters),
        .i_length   (r_wlen),
        .i_overlong (r_long),
        .o_kind     (word_kind)
    );

    assign flush_kind = (r_mode == MODE_NUM) ? exptok_pkg::KIND_NUMBER : word_kind;
    assign flush_pos  = (r_mode == MODE_WORD && word_kind == exptok_pkg::KIND_ERROR)
                        ? r_pos : '0;

    always_comb begin
        o_push_n = '0;
        if (i_fire) begin
            o_push_n = {1'b0, pending} + {1'b0, emit_own};
        end
        if (pending) begin
            if (r_mode == MODE_NUM) begin
                o_data0 = {flush_kind, r_mant, r_frac, r_sat, flush_pos, !emit_own};
            end else begin
                o_data0 = {flush_kind, MANTISSA_BITS'(0), FW'(0), 1'b0, flush_pos, !emit_own};
            end
        end else begin
            o_data0 = {own_kind, MANTISSA_BITS'(0), FW'(0), 1'b0, own_pos, 1'b1};
        end
        o_data1 = {own_kind, MANTISSA_BITS'(0), FW'(0), 1'b0, own_pos, 1'b1};
    end

    // number accumulate: start from zero or the pending value
    assign base_point = start_num_all ? 1'b0 : r_point;
    assign base_mant  = start_num_all ? '0 : r_mant;
    assign base_frac  = start_num_all ? '0 : r_frac;
    assign base_sat   = start_num_all ? 1'b0 : r_sat;
    assign mant_x10   = {1'b0, base_mant, 3'b000} + {3'b000, base_mant, 1'b0}
                        + (MANTISSA_BITS+4)'(i_char[3:0]);

    always_comb begin
        n_point = base_point;
        n_mant  = base_mant;
        n_frac  = base_frac;
        n_sat   = base_sat;
        if (is_point) begin
            n_point = 1'b1;
        end else begin
            if (base_point) begin
                if (base_frac < exptok_pkg::FRAC_MAX) begin
                    n_frac = base_frac + FW'(1);
                end else begin
                    n_sat = 1'b1;
                end
            end
            if (mant_x10[MANTISSA_BITS+3:MANTISSA_BITS] != 4'd0) begin
                n_mant = MANT_MAX;
                n_sat  = 1'b1;
            end else begin
                n_mant = mant_x10[MANTISSA_BITS-1:0];
            end
        end
    end

    // word letters, low byte first
    always_comb begin
        n_letters = r_letters;
        n_wlen    = r_wlen;
        n_long    = r_long;
        if (start_word_all) begin
            n_letters = {24'd0, i_char};
            n_wlen    = 3'd1;
            n_long    = 1'b0;
        end else if (r_wlen[2]) begin
            n_long = 1'b1;
        end else begin
            for (int b = 0; b < 4; b++) begin
                if (r_wlen[1:0] == 2'(b)) begin
                    n_letters[8*b +: 8] = i_char;
                end
            end
            n_wlen = r_wlen + 3'd1;
        end
    end

    always_comb begin
        if (start_num_all) begin
            n_mode = MODE_NUM;
        end else if (start_word_all) begin
            n_mode = MODE_WORD;
        end else if (handled) begin
            n_mode = r_mode;
        end else begin
            n_mode = MODE_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_prev <= exptok_pkg::CH_LPAREN;
            r_pos  <= '0;
        end else if (i_fire) begin
            if (i_char == exptok_pkg::CH_NUL) begin
                r_mode <= MODE_IDLE;
                r_prev <= exptok_pkg::CH_LPAREN;
                r_pos  <= '0;
            end else begin
                r_mode <= n_mode;
                r_pos  <= r_pos + POSITION_BITS'(1);
                if (second_point) begin
                    r_prev <= exptok_pkg::CH_POINT;
                end else if (!handled && !is_blank) begin
                    r_prev <= i_char;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && (num_cont || start_num_all)) begin
            r_point <= n_point;
            r_mant  <= n_mant;
            r_frac  <= n_frac;
            r_sat   <= n_sat;
        end
        if (i_fire && (word_cont || start_word_all)) begin
            r_letters <= n_letters;
            r_wlen    <= n_wlen;
            r_long    <= n_long;
        end
    end

endmodule

>>> rtl/exptok_fifo.sv
`include "expression_tokenizer_macros.svh"

module exptok_fifo #(
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [1:0]        i_push_n,
    input  logic [DATA_W-1:0] i_data0,
    input  logic [DATA_W-1:0] i_data1,
    input  logic              i_pop,
    output logic              o_room2,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_data
);

    localparam int DEPTH = exptok_pkg::RESULT_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr, r_rd, wr_next;
    logic [CNT_W-1:0]  r_count;

    assign wr_next = r_wr + PTR_W'(1);
    assign o_room2 = r_count <= CNT_W'(DEPTH - 2);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < DEPTH; i++) begin
            if (i_push_n != 2'd0 && r_wr == PTR_W'(i)) begin
                r_mem[i] <= i_data0;
            end else if (i_push_n == 2'd2 && wr_next == PTR_W'(i)) begin
                r_mem[i] <= i_data1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + PTR_W'(i_push_n);
            r_rd    <= r_rd + PTR_W'(i_pop);
            r_count <= r_count + CNT_W'(i_push_n) - CNT_W'(i_pop);
        end
    end

    `EXPTOK_ASSERT_IMP(a_count_max, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(DEPTH), "result queue over depth")
    `EXPTOK_ASSERT_IMP(a_push_room, i_clk, i_rst_n, i_push_n != 2'd0, o_room2, "push without room for two")
    `EXPTOK_ASSERT_NXT(a_push_two, i_clk, i_rst_n, i_push_n == 2'd2 && !i_pop, r_count == $past(r_count) + CNT_W'(2), "double push lost an entry")

endmodule

>>> rtl/expression_tokenizer.sv
// Channel   Valid     Ready     Payload
// input     i_valid   o_ready   i_char_code
// output    o_valid   i_ready   o_token_kind, o_number_mantissa, o_fraction_digits,
//                               o_number_saturated, o_error_position, o_last_in_run
//
// One character a cycle while o_ready is high: input register, combinational
// lexing logic, then a four-entry result queue. A character that closes a
// pending number or word and is a token itself gives two results, so the
// result side, at one a cycle while i_ready is high, paces such characters.
// Reset (i_rst_n low, synchronous) empties the queue and idles the lexer.
// o_ready drops only while the queue has room for fewer than two results.
module expression_tokenizer #(
    parameter int MANTISSA_BITS = exptok_pkg::MANTISSA_BITS_DEF,
    parameter int POSITION_BITS = exptok_pkg::POSITION_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [7:0]                     i_char_code,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [exptok_pkg::KIND_W-1:0]  o_token_kind,
    output logic [MANTISSA_BITS-1:0]       o_number_mantissa,
    output logic [exptok_pkg::FRAC_W-1:0]  o_fraction_digits,
    output logic                           o_number_saturated,
    output logic [POSITION_BITS-1:0]       o_error_position,
    output logic                           o_last_in_run
);

    localparam int DATA_W = exptok_pkg::KIND_W + MANTISSA_BITS
                            + exptok_pkg::FRAC_W + POSITION_BITS + 2;

    logic              r_in_valid;
    logic [7:0]        r_char;
    logic              core_fire, room2;
    logic [1:0]        push_n;
    logic [DATA_W-1:0] data0, data1, q_data;

    assign core_fire = r_in_valid && room2;
    assign o_ready   = !r_in_valid || core_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_char <= i_char_code;
        end
    end

    exptok_core #(
        .MANTISSA_BITS (MANTISSA_BITS),
        .POSITION_BITS (POSITION_BITS),
        .DATA_W        (DATA_W)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (core_fire),
        .i_char   (r_char),
        .o_push_n (push_n),
        .o_data0  (data0),
        .o_data1  (data1)
    );

    exptok_fifo #(
        .DATA_W (DATA_W)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (push_n),
        .i_data0  (data0),
        .i_data1  (data1),
        .i_pop    (o_valid && i_ready),
        .o_room2  (room2),
        .o_valid  (o_valid),
        .o_data   (q_data)
    );

    assign {o_token_kind, o_number_mantissa, o_fraction_digits, o_number_saturated,
            o_error_position, o_last_in_run} = q_data;

endmodule

>>> verif/expression_tokenizer_test.sv
module expression_tokenizer_test;

    localparam int MANT_W = exptok_pkg::MANTISSA_BITS_DEF;
    localparam int POS_W = exptok_pkg::POSITION_BITS_DEF;
    localparam int KIND_W = exptok_pkg::KIND_W;
    localparam int FRAC_W = exptok_pkg::FRAC_W;
    localparam int FUNC_COUNT = exptok_pkg::FUNC_COUNT;
    localparam logic [MANT_W-1:0] MANT_MAX = {MANT_W{1'b1}};
    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_CHARS = 1800;
    localparam int HOLD_AFTER = 300;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 8;
    localparam logic [7:0] CH_UPPERQ = "Q";

    typedef enum logic [1:0] {
        LEX_IDLE,
        LEX_NUMBER,
        LEX_WORD
    } t_lex_mode;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [MANT_W-1:0] mant;
        logic [FRAC_W-1:0] frac;
        logic              sat;
        logic [POS_W-1:0]  pos;
        logic              last;
    } t_token;

    typedef struct {
        logic [7:0]        ch;
        logic              known;
        logic [KIND_W-1:0] kind;
    } t_probe;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_ready;
    logic [7:0]        i_char_code = '0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic [KIND_W-1:0] o_token_kind;
    logic [MANT_W-1:0] o_number_mantissa;
    logic [FRAC_W-1:0] o_fraction_digits;
    logic              o_number_saturated;
    logic [POS_W-1:0]  o_error_position;
    logic              o_last_in_run;

    expression_tokenizer dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_char_code        (i_char_code),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_token_kind       (o_token_kind),
        .o_number_mantissa  (o_number_mantissa),
        .o_fraction_digits  (o_fraction_digits),
        .o_number_saturated (o_number_saturated),
        .o_error_position   (o_error_position),
        .o_last_in_run      (o_last_in_run)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Lexer state mirrored from the block
    logic [7:0]        prev_sig;
    logic [POS_W-1:0]  char_index;
    t_lex_mode         lex_mode;
    logic              point_seen;
    logic [MANT_W-1:0] mant_acc;
    logic [FRAC_W-1:0] frac_cnt;
    logic              sat_seen;
    logic [31:0]       word_buf;
    logic [2:0]        word_len;
    logic              word_long;

    string fn_names [FUNC_COUNT] = '{"sin", "cos", "tan", "sinh", "cosh", "tanh",
                                     "ln", "exp", "sqrt", "log", "abs"};
    logic [7:0] op_chars [5] = '{exptok_pkg::CH_PLUS, exptok_pkg::CH_MINUS,
                                 exptok_pkg::CH_STAR, exptok_pkg::CH_SLASH,
                                 exptok_pkg::CH_CARET};

    t_token expected_tokens [$];
    t_token step_tokens [$];

    int  fail_count = 0;
    int  chars_sent = 0;
    int  tokens_checked = 0;
    int  saturated_seen = 0;
    int  stall_cycles = 0;
    int  cycle_count = 0;
    int  burst_left = 0;
    bit  valid_up = 1'b0;
    bit  kinds_seen [32];

    int  hold_left = 0;
    bit  hold_done = 1'b0;
    int  pattern_left = 0;
    int  pattern_mode = 0;
    bit  take;

    function automatic bit is_digit(logic [7:0] c);
        return c >= exptok_pkg::CH_ZERO && c <= exptok_pkg::CH_NINE;
    endfunction

    function automatic bit is_lower(logic [7:0] c);
        return c >= exptok_pkg::CH_LOWA && c <= exptok_pkg::CH_LOWZ;
    endfunction

    function automatic void clear_lexer();
        prev_sig = exptok_pkg::CH_LPAREN;
        char_index = '0;
        lex_mode = LEX_IDLE;
        point_seen = 1'b0;
        mant_acc = '0;
        frac_cnt = '0;
        sat_seen = 1'b0;
        word_buf = '0;
        word_len = '0;
        word_long = 1'b0;
    endfunction

    function automatic void add_token(logic [KIND_W-1:0] kind, logic [MANT_W-1:0] mant,
                                      logic [FRAC_W-1:0] frac, logic sat,
                                      logic [POS_W-1:0] pos);
        t_token t;
        t.kind = kind;
        t.mant = mant;
        t.frac = frac;
        t.sat = sat;
        t.pos = pos;
        t.last = 1'b0;
        step_tokens.push_back(t);
    endfunction

    function automatic void take_digit(logic [7:0] c);
        logic [MANT_W-1:0] d;
        if (c == exptok_pkg::CH_POINT) begin
            point_seen = 1'b1;
        end else begin
            d = MANT_W'(c - exptok_pkg::CH_ZERO);
            if (point_seen) begin
                if (frac_cnt < exptok_pkg::FRAC_MAX) frac_cnt++;
                else sat_seen = 1'b1;
            end
            // clamp at all ones rather than wrap
            if (mant_acc > (MANT_MAX - d) / 10) begin
                mant_acc = MANT_MAX;
                sat_seen = 1'b1;
            end else begin
                mant_acc = mant_acc * 10 + d;
            end
        end
    endfunction

    function automatic void start_number(logic [7:0] c);
        lex_mode = LEX_NUMBER;
        point_seen = 1'b0;
        mant_acc = '0;
        frac_cnt = '0;
        sat_seen = 1'b0;
        take_digit(c);
    endfunction

    function automatic void take_letter(logic [7:0] c);
        if (word_len < 4) begin
            word_buf[8*word_len +: 8] = c;
            word_len++;
        end else begin
            word_long = 1'b1;
        end
    endfunction

    function automatic logic [KIND_W-1:0] word_kind();
        logic [31:0]       name_bits;
        logic [KIND_W-1:0] k;
        k = exptok_pkg::KIND_ERROR;
        if (!word_long) begin
            for (int i = 0; i < FUNC_COUNT; i++) begin
                name_bits = '0;
                for (int j = 0; j < fn_names[i].len(); j++)
                    name_bits[8*j +: 8] = fn_names[i][j];
                if (fn_names[i].len() == word_len && name_bits == word_buf)
                    k = KIND_W'(exptok_pkg::KIND_FUNC0 + i);
            end
        end
        return k;
    endfunction

    function automatic void close_pending();
        logic [KIND_W-1:0] k;
        if (lex_mode == LEX_NUMBER) begin
            add_token(exptok_pkg::KIND_NUMBER, mant_acc, frac_cnt, sat_seen, '0);
        end else if (lex_mode == LEX_WORD) begin
            k = word_kind();
            add_token(k, '0, '0, 1'b0, (k == exptok_pkg::KIND_ERROR) ? char_index : '0);
        end
        lex_mode = LEX_IDLE;
    endfunction

    // Work out the tokens one accepted character completes
    function automatic void lex_char(logic [7:0] c);
        logic [7:0] prior;
        bit         consumed;
        prior = prev_sig;
        consumed = 1'b0;
        step_tokens.delete();
        if (lex_mode == LEX_NUMBER && (is_digit(c) || c == exptok_pkg::CH_POINT)) begin
            if (c == exptok_pkg::CH_POINT && point_seen) begin
                close_pending();
                start_number(c);
                prev_sig = c;
            end else begin
                take_digit(c);
            end
            consumed = 1'b1;
        end else if (lex_mode == LEX_WORD && is_lower(c)) begin
            take_letter(c);
            consumed = 1'b1;
        end
        if (!consumed) begin
            close_pending();
            if (c == exptok_pkg::CH_NUL) begin
                add_token(exptok_pkg::KIND_END, '0, '0, 1'b0, '0);
                clear_lexer();
            end else if (c != exptok_pkg::CH_SPACE && c != exptok_pkg::CH_TAB) begin
                prev_sig = c;
                case (c)
                    exptok_pkg::CH_PLUS: begin
                        add_token((prior == exptok_pkg::CH_LPAREN
                                   || prior == exptok_pkg::CH_MINUS
                                   || prior == exptok_pkg::CH_STAR
                                   || prior == exptok_pkg::CH_SLASH)
                                  ? exptok_pkg::KIND_UPLUS : exptok_pkg::KIND_PLUS,
                                  '0, '0, 1'b0, '0);
                    end
                    exptok_pkg::CH_MINUS: begin
                        add_token((prior == exptok_pkg::CH_LPAREN
                                   || prior == exptok_pkg::CH_PLUS
                                   || prior == exptok_pkg::CH_STAR
                                   || prior == exptok_pkg::CH_SLASH)
                                  ? exptok_pkg::KIND_UMINUS : exptok_pkg::KIND_MINUS,
                                  '0, '0, 1'b0, '0);
                    end
                    exptok_pkg::CH_STAR: add_token(exptok_pkg::KIND_STAR, '0, '0, 1'b0, '0);
                    exptok_pkg::CH_SLASH: add_token(exptok_pkg::KIND_DIV, '0, '0, 1'b0, '0);
                    exptok_pkg::CH_CARET: add_token(exptok_pkg::KIND_POW, '0, '0, 1'b0, '0);
                    exptok_pkg::CH_LOWX, exptok_pkg::CH_UPPERX: begin
                        add_token(exptok_pkg::KIND_X, '0, '0, 1'b0, '0);
                    end
                    exptok_pkg::CH_LPAREN: begin
                        add_token(exptok_pkg::KIND_LPAREN, '0, '0, 1'b0, '0);
                    end
                    exptok_pkg::CH_RPAREN: begin
                        add_token(exptok_pkg::KIND_RPAREN, '0, '0, 1'b0, '0);
                    end
                    default: begin
                        if (is_digit(c) || c == exptok_pkg::CH_POINT) begin
                            start_number(c);
                        end else if (is_lower(c)) begin
                            lex_mode = LEX_WORD;
                            word_buf = '0;
                            word_len = '0;
                            word_long = 1'b0;
                            take_letter(c);
                        end else begin
                            add_token(exptok_pkg::KIND_ERROR, '0, '0, 1'b0, char_index);
                        end
                    end
                endcase
            end
        end
        if (c != exptok_pkg::CH_NUL) char_index++;
        if (step_tokens.size() > 0) step_tokens[step_tokens.size()-1].last = 1'b1;
        foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
    endfunction

    // Offer one request, hold it until taken, then maybe drop valid for a gap
    task automatic send_char(input logic [7:0] c);
        i_valid <= 1'b1;
        i_char_code <= c;
        valid_up = 1'b1;
        do @(posedge i_clk); while (!o_ready);
        lex_char(c);
        chars_sent++;
        if (burst_left == 0) begin
            i_valid <= 1'b0;
            valid_up = 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 20);
        end else begin
            burst_left--;
        end
    endtask

    task automatic send_string(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i]);
    endtask

    task automatic send_digits(input int count);
        repeat (count) send_char(exptok_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    task automatic send_random_number();
        int shape;
        int int_digits;
        int frac_digits;
        shape = $urandom_range(0, 99);
        int_digits = $urandom_range(0, 5);
        frac_digits = -1;
        if (shape < 5) begin
            int_digits = $urandom_range(17, 24);
        end else if (shape < 8) begin
            int_digits = $urandom_range(0, 3);
            frac_digits = $urandom_range(60, 68);
        end else if (shape < 50) begin
            frac_digits = $urandom_range(0, 6);
        end
        if (int_digits == 0 && frac_digits < 0) int_digits = 1;
        send_digits(int_digits);
        if (frac_digits >= 0) begin
            send_char(exptok_pkg::CH_POINT);
            send_digits(frac_digits);
        end
        // a point after an integer-only number, then zero to three fraction digits
        if (shape >= 90) begin
            send_char(exptok_pkg::CH_POINT);
            send_digits($urandom_range(0, 3));
        end
    endtask

    task automatic send_random_word();
        repeat ($urandom_range(1, 7)) begin
            send_char(exptok_pkg::CH_LOWA + 8'($urandom_range(0, 25)));
        end
    endtask

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    t_probe probes [25] = '{
        '{exptok_pkg::CH_PLUS,   1'b1, exptok_pkg::KIND_UPLUS},
        '{exptok_pkg::CH_MINUS,  1'b1, exptok_pkg::KIND_UMINUS},
        '{"5",                   1'b0, exptok_pkg::KIND_END},
        '{exptok_pkg::CH_POINT,  1'b0, exptok_pkg::KIND_END},
        '{"2",                   1'b0, exptok_pkg::KIND_END},
        '{exptok_pkg::CH_POINT,  1'b0, exptok_pkg::KIND_END},
        '{exptok_pkg::CH_STAR,   1'b0, exptok_pkg::KIND_END},
        '{exptok_pkg::CH_LOWX,   1'b1, exptok_pkg::KIND_X},
        '{exptok_pkg::CH_CARET,  1'b1, exptok_pkg::KIND_POW},
        '{"s",                   1'b0, exptok_pkg::KIND_END},
        '{"i",                   1'b0, exptok_pkg::KIND_END},
        '{"n",                   1'b0, exptok_pkg::KIND_END},
        '{"h",                   1'b0, exptok_pkg::KIND_END},
        '{exptok_pkg::CH_LPAREN, 1'b1, exptok_pkg::KIND_LPAREN},
        '{exptok_pkg::CH_UPPERX, 1'b1, exptok_pkg::KIND_X},
        '{exptok_pkg::CH_RPAREN, 1'b1, exptok_pkg::KIND_RPAREN},
        '{exptok_pkg::CH_SLASH,  1'b1, exptok_pkg::KIND_DIV},
        '{CH_UPPERQ,             1'b1, exptok_pkg::KIND_ERROR},
        '{8'hFF,                 1'b1, exptok_pkg::KIND_ERROR},
        '{exptok_pkg::CH_SPACE,  1'b0, exptok_pkg::KIND_END},
        '{exptok_pkg::CH_TAB,    1'b0, exptok_pkg::KIND_END},
        '{exptok_pkg::CH_MINUS,  1'b1, exptok_pkg::KIND_MINUS},
        '{"q",                   1'b0, exptok_pkg::KIND_END},
        '{"z",                   1'b0, exptok_pkg::KIND_END},
        '{exptok_pkg::CH_NUL,    1'b1, exptok_pkg::KIND_END}
    };

    initial begin
        int goal;
        int pick;
        int kinds_total;
        clear_lexer();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (probes[i]) begin
            send_char(probes[i].ch);
            if (probes[i].known && (step_tokens.size() == 0
                    || step_tokens[step_tokens.size()-1].kind != probes[i].kind)) begin
                $error("directed row %0d: predicted token does not match table", i);
                fail_count++;
            end
        end

        // mantissa right at the top, one past it, then a fraction count that clamps
        send_string("1152921504606846975 1152921504606846976 ");
        send_string("999.");
        send_digits(66);
        send_char(exptok_pkg::CH_NUL);

        goal = chars_sent + RANDOM_CHARS;
        while (chars_sent < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
                send_random_number();
            end else if (pick < 43) begin
                send_char(op_chars[$urandom_range(0, 4)]);
            end else if (pick < 53) begin
                send_string(fn_names[$urandom_range(0, FUNC_COUNT - 1)]);
                send_char(exptok_pkg::CH_LPAREN);
            end else if (pick < 61) begin
                send_char($urandom_range(0, 1) ? exptok_pkg::CH_LPAREN
                                               : exptok_pkg::CH_RPAREN);
            end else if (pick < 67) begin
                send_char($urandom_range(0, 1) ? exptok_pkg::CH_LOWX
                                               : exptok_pkg::CH_UPPERX);
            end else if (pick < 75) begin
                repeat ($urandom_range(1, 3)) begin
                    send_char($urandom_range(0, 1) ? exptok_pkg::CH_SPACE
                                                   : exptok_pkg::CH_TAB);
                end
            end else if (pick < 82) begin
                send_random_word();
            end else if (pick < 90) begin
                send_char(8'($urandom_range(0, 255)));
            end else begin
                send_char(exptok_pkg::CH_NUL);
            end
        end
        if (valid_up) i_valid <= 1'b0;

        while (expected_tokens.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        kinds_total = 0;
        foreach (kinds_seen[k]) if (kinds_seen[k]) kinds_total++;
        $display("Lexed %0d characters, checked %0d tokens covering %0d of 24 token kinds.",
                 chars_sent, tokens_checked, kinds_total);
        $display("Saw %0d saturated numbers; input was held back for %0d cycles.",
                 saturated_seen, stall_cycles);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Result side: check each token taken, then pick next cycle's ready
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_ready) stall_cycles++;
            if (o_valid && i_ready) begin
                if (expected_tokens.size() == 0) begin
                    $error("token_kind: expected no token, got %0d", o_token_kind);
                    fail_count++;
                end else begin
                    t_token want;
                    want = expected_tokens.pop_front();
                    check_field("token_kind", want.kind, o_token_kind);
                    check_field("number_mantissa", want.mant, o_number_mantissa);
                    check_field("fraction_digits", want.frac, o_fraction_digits);
                    check_field("number_saturated", want.sat, o_number_saturated);
                    check_field("error_position", want.pos, o_error_position);
                    check_field("last_in_run", want.last, o_last_in_run);
                end
                tokens_checked++;
                kinds_seen[o_token_kind] = 1'b1;
                if (o_number_saturated) saturated_seen++;
            end

            if (hold_left > 0) begin
                hold_left--;
            end else if (!hold_done && tokens_checked >= HOLD_AFTER) begin
                // starve the result side so the queue fills and input stalls
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end

            if (pattern_left == 0) begin
                pattern_mode = $urandom_range(0, 2);
                pattern_left = $urandom_range(32, 256);
            end else begin
                pattern_left--;
            end
            case (pattern_mode)
                0: take = 1'b1;
                1: take = $urandom_range(0, 1);
                default: take = ($urandom_range(0, 3) == 0);
            endcase
            i_ready <= (hold_left == 0) && take;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

endmodule
